[design/scs_pkg.sv]
// Shared types, constants and codes for the sigma-clipped statistics block.
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;

    localparam int SAMPLE_W = 16;
    localparam int MEAN_W   = 24;
    localparam int DEV_W    = 24;
    localparam int KEPT_W   = 13;
    localparam int PASS_W   = 4;
    localparam int FACTOR_W = 12;
    localparam int WIDTH_W  = FACTOR_W + DEV_W;

    // Operand widths of the shared iterative unit.
    localparam int ITER_W   = 64;
    localparam int OPB_W    = 33;
    localparam int DIV_W    = 41;
    localparam int QUO_W    = 41;
    localparam int ACC_W    = 66;
    localparam int SHIFT_W  = 80;
    localparam int ICNT_W   = 7;

    // Step counts minus one for each operation.
    localparam int MUL_STEPS  = OPB_W - 1;
    localparam int DIV_STEPS  = DIV_W - 1;
    localparam int SQRT_STEPS = SHIFT_W / 2 - 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_PASSES = 1'b0;
    localparam logic CFG_IDX_FACTOR = 1'b1;

    localparam int RESET_PASSES = 3;
    localparam int RESET_FACTOR = 768;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } iter_op_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_STAT,
        ST_MEAN,
        ST_MULA,
        ST_MULB,
        ST_SQRT,
        ST_DEV,
        ST_WIDTH,
        ST_CLIP,
        ST_DONE
    } scs_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_q8;
        logic [DEV_W-1:0]  stddev_q8;
        logic [KEPT_W-1:0] kept_count;
    } out_item_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_ctrl_t;

endpackage
`default_nettype wire

[design/scs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module scs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[design/scs_iter.sv]
// Shared iterative unit: shift-add multiply, restoring divide and square root.
`timescale 1ns / 1ps
`default_nettype none
module scs_iter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire scs_pkg::iter_ctrl_t        ctrl,
    input  wire logic [scs_pkg::ITER_W-1:0] a_in,
    input  wire logic [scs_pkg::OPB_W-1:0]  b_in,
    output logic                            done,
    output logic      [scs_pkg::ITER_W-1:0] result
);
    import scs_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    iter_op_t           op_reg;
    logic [ICNT_W-1:0]  cnt_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [SHIFT_W-1:0] opa_reg;
    logic [OPB_W-1:0]   opb_reg;
    logic [QUO_W-1:0]   q_reg;

    logic [ACC_W-1:0]   add_a;
    logic [ACC_W-1:0]   add_b;
    logic               add_sub;
    logic [ACC_W:0]     add_sum;
    logic               fits;

    // One adder serves every operation; for a subtract the carry out
    // says the difference is not negative.
    always_comb
    begin
        add_a   = acc_reg;
        add_b   = '0;
        add_sub = 1'b0;
        case (op_reg)
            OP_MUL:
            begin
                add_a   = acc_reg;
                add_b   = {2'b00, opa_reg[ITER_W-1:0]} & {ACC_W{opb_reg[0]}};
                add_sub = 1'b0;
            end
            OP_DIV:
            begin
                add_a   = {acc_reg[ACC_W-2:0], opa_reg[SHIFT_W-1]};
                add_b   = ACC_W'(opb_reg);
                add_sub = 1'b1;
            end
            OP_SQRT:
            begin
                add_a   = {acc_reg[ACC_W-3:0], opa_reg[SHIFT_W-1:SHIFT_W-2]};
                add_b   = ACC_W'({q_reg, 2'b01});
                add_sub = 1'b1;
            end
            default:
            begin
                add_a   = acc_reg;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                  + (ACC_W+1)'(add_sub);
        fits    = add_sum[ACC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctrl.op;
                case (ctrl.op)
                    OP_MUL:  cnt_reg <= ICNT_W'(MUL_STEPS);
                    OP_DIV:  cnt_reg <= ICNT_W'(DIV_STEPS);
                    OP_SQRT: cnt_reg <= ICNT_W'(SQRT_STEPS);
                    default: cnt_reg <= ICNT_W'(MUL_STEPS);
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            acc_reg <= '0;
            q_reg   <= '0;
            opb_reg <= b_in;
            case (ctrl.op)
                OP_MUL:  opa_reg <= SHIFT_W'(a_in);
                OP_DIV:  opa_reg <= {a_in[DIV_W-1:0], {(SHIFT_W-DIV_W){1'b0}}};
                OP_SQRT: opa_reg <= {a_in, {(SHIFT_W-ITER_W){1'b0}}};
                default: opa_reg <= SHIFT_W'(a_in);
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    acc_reg <= add_sum[ACC_W-1:0];
                    opa_reg <= {opa_reg[SHIFT_W-2:0], 1'b0};
                    opb_reg <= {1'b0, opb_reg[OPB_W-1:1]};
                end
                OP_DIV:
                begin
                    acc_reg <= fits ? add_sum[ACC_W-1:0] : add_a;
                    q_reg   <= {q_reg[QUO_W-2:0], fits};
                    opa_reg <= {opa_reg[SHIFT_W-2:0], 1'b0};
                end
                OP_SQRT:
                begin
                    acc_reg <= fits ? add_sum[ACC_W-1:0] : add_a;
                    q_reg   <= {q_reg[QUO_W-2:0], fits};
                    opa_reg <= {opa_reg[SHIFT_W-3:0], 2'b00};
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == OP_MUL) ? acc_reg[ITER_W-1:0] : ITER_W'(q_reg);

endmodule
`default_nettype wire

[design/sigma_clipped_stats.sv]
// Top level of the sigma-clipped background statistics block.
//
// Samples arrive on the input channel, one item per cycle while in_stall
// is low. Samples up to MAX_SAMPLES are stored in a memory with a keep
// flag. The item with last set ends the set: in_stall then goes high and
// the block runs its clipping passes over the stored samples, one memory
// read per cycle, with a single iterative unit doing the multiply,
// divide and square root steps one bit per cycle.
// Each statistics pass scans the stored samples, then has the iterative
// unit do a divide for the mean, two multiplies of 33 steps, a square
// root of 40 steps and a divide for the deviation, each divide of 41
// steps. Each clipping pass computes the rejection width and scans
// again, clearing the keep flag of samples outside it. Passes stop early
// when no sample is kept or the variance is zero. The result item waits
// in an output register until out_stall is low; the block loads the
// next set meanwhile and holds only when a second result is ready while
// the first is still waiting. Reset empties the sample memory logically
// (the fill count returns to zero), restores three passes and a factor
// of 3.0, and clears out_valid. Configuration is written over the APB
// port; the user must do so only while idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module sigma_clipped_stats #(
    parameter int MAX_SAMPLES = scs_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire scs_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output scs_pkg::out_item_t                  out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [scs_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [scs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [scs_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import scs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_W + CNT_W;
    localparam int RAM_W  = SAMPLE_W + 1;

    scs_state_t state_reg, state_next;

    logic [PASS_W-1:0]   passes_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic                cfg_write;

    logic [CNT_W-1:0]    loaded_reg;
    logic [PASS_W-1:0]   pass_cnt_reg;
    logic                go_reg;

    logic [CNT_W-1:0]    issue_reg;
    logic                s1_valid_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic                s2_valid_reg;
    logic [SAMPLE_W-1:0] s2_v_reg;
    logic [2*SAMPLE_W-1:0] sq_reg;

    logic [CNT_W-1:0]    n_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sumsq_reg;

    logic [MEAN_W-1:0]   mean_reg;
    logic [DEV_W-1:0]    dev_reg;
    logic [ITER_W-1:0]   prod_reg;
    logic [ITER_W-1:0]   d_reg;
    logic [WIDTH_W-1:0]  width_reg;

    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                in_accept;
    logic                scanning;
    logic                issue;
    logic                scan_done;
    logic                enter;
    logic                out_free;
    logic                stop_clip;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;

    logic [SAMPLE_W-1:0] rd_v;
    logic                rd_keep;
    logic [2*SAMPLE_W-1:0] v_shift;
    logic [2*SAMPLE_W-1:0] c_shift;
    logic [2*SAMPLE_W-1:0] abs_diff;
    logic                drop;

    iter_ctrl_t          iter_ctrl;
    logic [ITER_W-1:0]   iter_a;
    logic [OPB_W-1:0]    iter_b;
    logic                iter_done;
    logic [ITER_W-1:0]   iter_result;

    // Configuration port.
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == CFG_IDX_FACTOR) ? CFG_DATA_W'(factor_reg)
                                                     : CFG_DATA_W'(passes_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            passes_reg <= PASS_W'(RESET_PASSES);
            factor_reg <= FACTOR_W'(RESET_FACTOR);
        end
        else if (cfg_write)
        begin
            if (paddr[2] == CFG_IDX_PASSES)
            begin
                passes_reg <= pwdata[PASS_W-1:0];
            end
            else
            begin
                factor_reg <= pwdata[FACTOR_W-1:0];
            end
        end
    end

    // Scan and status terms.
    assign in_accept = in_valid && !in_stall;
    assign scanning  = (state_reg == ST_STAT) || (state_reg == ST_CLIP);
    assign issue     = scanning && (issue_reg < loaded_reg);
    assign scan_done = scanning && (issue_reg == loaded_reg)
                       && !s1_valid_reg && !s2_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign stop_clip = (d_reg == '0) || (pass_cnt_reg == passes_reg);

    // Clip test on the sample coming out of the memory.
    assign rd_v     = ram_rdata[SAMPLE_W-1:0];
    assign rd_keep  = ram_rdata[SAMPLE_W];
    assign v_shift  = {rd_v, {SAMPLE_W{1'b0}}};
    assign c_shift  = {mean_reg, 8'b0};
    assign abs_diff = (v_shift >= c_shift) ? (v_shift - c_shift) : (c_shift - v_shift);
    assign drop     = WIDTH_W'(abs_diff) > width_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && in_data.last)
                begin
                    state_next = ST_STAT;
                end
            end
            ST_STAT:
            begin
                if (scan_done)
                begin
                    state_next = (n_reg == '0) ? ST_DONE : ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (iter_done)
                begin
                    state_next = ST_MULA;
                end
            end
            ST_MULA:
            begin
                if (iter_done)
                begin
                    state_next = ST_MULB;
                end
            end
            ST_MULB:
            begin
                if (iter_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (iter_done)
                begin
                    state_next = ST_DEV;
                end
            end
            ST_DEV:
            begin
                if (iter_done)
                begin
                    state_next = stop_clip ? ST_DONE : ST_WIDTH;
                end
            end
            ST_WIDTH:
            begin
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                if (scan_done)
                begin
                    state_next = ST_STAT;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign enter = (state_next != state_reg);

    // State-driven outputs: handshake and the shared unit's operands.
    always_comb
    begin
        in_stall       = (state_reg != ST_LOAD);
        iter_ctrl.start = 1'b0;
        iter_ctrl.op    = OP_MUL;
        iter_a          = '0;
        iter_b          = '0;
        case (state_reg)
            ST_MEAN:
            begin
                iter_ctrl.start = go_reg;
                iter_ctrl.op    = OP_DIV;
                iter_a = ITER_W'({sum_reg, 8'b0}) + ITER_W'(n_reg >> 1);
                iter_b = OPB_W'(n_reg);
            end
            ST_MULA:
            begin
                iter_ctrl.start = go_reg;
                iter_ctrl.op    = OP_MUL;
                iter_a = ITER_W'(sumsq_reg);
                iter_b = OPB_W'(n_reg);
            end
            ST_MULB:
            begin
                iter_ctrl.start = go_reg;
                iter_ctrl.op    = OP_MUL;
                iter_a = ITER_W'(sum_reg);
                iter_b = OPB_W'(sum_reg);
            end
            ST_SQRT:
            begin
                iter_ctrl.start = go_reg;
                iter_ctrl.op    = OP_SQRT;
                iter_a = d_reg;
                iter_b = '0;
            end
            ST_DEV:
            begin
                iter_ctrl.start = go_reg;
                iter_ctrl.op    = OP_DIV;
                iter_a = iter_result;
                iter_b = OPB_W'(n_reg);
            end
            default:
            begin
                iter_ctrl.start = 1'b0;
            end
        endcase
    end

    // Sample memory port: loads write new samples, clipping clears flags.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = loaded_reg[ADDR_W-1:0];
        ram_wdata = {1'b1, in_data.sample};
        if (state_reg == ST_LOAD)
        begin
            ram_we = in_accept && (loaded_reg < CNT_W'(MAX_SAMPLES));
        end
        else if (state_reg == ST_CLIP)
        begin
            ram_we    = s1_valid_reg && rd_keep && drop;
            ram_waddr = s1_addr_reg;
            ram_wdata = {1'b0, rd_v};
        end
    end

    scs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    scs_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (iter_ctrl),
        .a_in   (iter_a),
        .b_in   (iter_b),
        .done   (iter_done),
        .result (iter_result)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            loaded_reg    <= '0;
            pass_cnt_reg  <= '0;
            go_reg        <= 1'b0;
            issue_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            go_reg       <= enter;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg && rd_keep && (state_reg == ST_STAT);

            if (enter)
            begin
                issue_reg <= '0;
            end
            else if (issue)
            begin
                issue_reg <= issue_reg + 1'b1;
            end

            if (state_reg == ST_LOAD && in_accept)
            begin
                if (loaded_reg < CNT_W'(MAX_SAMPLES))
                begin
                    loaded_reg <= loaded_reg + 1'b1;
                end
                pass_cnt_reg <= '0;
            end
            if (state_reg == ST_CLIP && scan_done)
            begin
                pass_cnt_reg <= pass_cnt_reg + 1'b1;
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                loaded_reg    <= '0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        s1_addr_reg <= issue_reg[ADDR_W-1:0];
        s2_v_reg    <= rd_v;
        sq_reg      <= rd_v * rd_v;

        if (state_reg == ST_LOAD && in_accept && in_data.last)
        begin
            mean_reg <= '0;
            dev_reg  <= '0;
        end

        if (enter && state_next == ST_STAT)
        begin
            n_reg     <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            n_reg     <= n_reg + 1'b1;
            sum_reg   <= sum_reg + SUM_W'(s2_v_reg);
            sumsq_reg <= sumsq_reg + SQ_W'(sq_reg);
        end

        if (iter_done)
        begin
            case (state_reg)
                ST_MEAN: mean_reg <= iter_result[MEAN_W-1:0];
                ST_MULA: prod_reg <= iter_result;
                ST_MULB: d_reg    <= prod_reg - iter_result;
                ST_DEV:  dev_reg  <= iter_result[DEV_W-1:0];
                default: prod_reg <= prod_reg;
            endcase
        end

        if (state_reg == ST_WIDTH)
        begin
            width_reg <= factor_reg * dev_reg;
        end

        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg.mean_q8    <= mean_reg;
            out_data_reg.stddev_q8  <= dev_reg;
            out_data_reg.kept_count <= KEPT_W'(n_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the sigma-clipped background statistics block.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import scs_pkg::*;

    localparam int NMAX = MAX_SAMPLES_DEF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    out_item_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    sigma_clipped_stats u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state.
    logic [PASS_W-1:0]   mdl_passes = PASS_W'(RESET_PASSES);
    logic [FACTOR_W-1:0] mdl_factor = FACTOR_W'(RESET_FACTOR);
    logic [15:0] set_vals [NMAX];
    bit          set_keep [NMAX];
    int          set_len = 0;
    logic [23:0] cur_mean, cur_dev;

    out_item_t stats_queue[$];
    int  fail_count = 0;
    bit  rx_hold = 1'b0;
    bit  quiet_rx = 1'b0;
    bit  quiet_tx = 1'b0;

    // Statistics of the kept set; leaves the running values alone when empty.
    function automatic int kept_moments(output bit [63:0] num);
        bit [63:0] n, s, sq, d, t, c;
        bit [127:0] lhs, rhs;
        n = 0; s = 0; sq = 0; t = 0;
        for (int i = 0; i < set_len; i++)
            if (set_keep[i])
            begin
                n++;
                s += set_vals[i];
                sq += 64'(set_vals[i]) * set_vals[i];
            end
        num = 0;
        if (n == 0)
            return 0;
        cur_mean = 24'(((s << 8) + n / 2) / n);
        d = n * sq - s * s;
        num = d;
        rhs = {64'd0, d} << 16;
        for (int b = 23; b >= 0; b--)
        begin
            c = t | (64'd1 << b);
            lhs = 128'(c * n) * 128'(c * n);
            if (lhs <= rhs)
                t = c;
        end
        cur_dev = 24'(t);
        return int'(n);
    endfunction

    function automatic void clip_kept();
        longint centre, width, diff;
        centre = longint'(cur_mean) * 256;
        width = longint'(mdl_factor) * longint'(cur_dev);
        for (int i = 0; i < set_len; i++)
            if (set_keep[i])
            begin
                diff = longint'(set_vals[i]) * 65536 - centre;
                if (diff < 0)
                    diff = -diff;
                if (diff > width)
                    set_keep[i] = 1'b0;
            end
    endfunction

    function automatic void predict_sample(in_item_t it);
        bit [63:0] num;
        int kept;
        out_item_t r;
        if (set_len < NMAX)
        begin
            set_vals[set_len] = it.sample;
            set_keep[set_len] = 1'b1;
            set_len++;
        end
        if (!it.last)
            return;
        cur_mean = 0;
        cur_dev = 0;
        kept = set_len;
        for (int p = 0; p < mdl_passes; p++)
        begin
            if (kept == 0)
                break;
            void'(kept_moments(num));
            if (num == 0)
                break;
            clip_kept();
            kept = kept_moments(num);
        end
        kept = kept_moments(num);
        r.mean_q8 = cur_mean;
        r.stddev_q8 = cur_dev;
        r.kept_count = KEPT_W'(kept);
        stats_queue.insert(stats_queue.size(), r);
        set_len = 0;
    endfunction

    // Returns at the accepting edge; the next falling edge drives the next item.
    task automatic send_sample(input logic [15:0] v, input bit lst);
        in_item_t it;
        int gap;
        it.sample = v;
        it.last = lst;
        gap = quiet_tx ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sample(it);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (stats_queue.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (a == CFG_ADDR_W'(4 * CFG_IDX_PASSES))
            mdl_passes = d[PASS_W-1:0];
        else if (a == CFG_ADDR_W'(4 * CFG_IDX_FACTOR))
            mdl_factor = d[FACTOR_W-1:0];
    endtask

    task automatic set_config(input int passes, input int factor);
        drain_results();
        write_reg(CFG_ADDR_W'(4 * CFG_IDX_PASSES), 32'(passes));
        write_reg(CFG_ADDR_W'(4 * CFG_IDX_FACTOR), 32'(factor));
    endtask

    // A set is samples around a base with some outliers, or all random if wide.
    task automatic send_set(input int len, input bit wide);
        int base;
        logic [15:0] v;
        base = $urandom_range(0, 65535);
        for (int i = 0; i < len; i++)
        begin
            if (wide || $urandom_range(0, 9) == 0)
                v = 16'($urandom);
            else
                v = 16'(base + $urandom_range(0, 64) - 32);
            send_sample(v, i == len - 1);
        end
    endtask

    task automatic test_directed();
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        for (int i = 0; i < 5; i++)
            send_sample(16'd1234, i == 4);
        for (int i = 0; i < 6; i++)
            send_sample(i == 5 ? 16'hFFFF : 16'd100, i == 5);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h0001, 1'b1);
    endtask

    task automatic test_config_extremes();
        set_config(0, 768);
        send_set(6, 1'b1);
        set_config(15, 0);
        send_set(7, 1'b0);
        set_config(15, 4095);
        send_set(8, 1'b1);
        set_config(1, 128);
        send_set(8, 1'b0);
    endtask

    task automatic test_random();
        for (int k = 0; k < 15; k++)
        begin
            if (k % 8 == 0)
                set_config($urandom_range(0, 15), $urandom_range(0, 4095));
            send_set($urandom_range(1, 20), $urandom_range(0, 4) == 0);
        end
    endtask

    // The receiver holds off while whole sets keep arriving without gaps.
    task automatic test_backpressure();
        set_config(2, 768);
        quiet_tx = 1'b1;
        rx_hold = 1'b1;
        for (int k = 0; k < 4; k++)
            send_set(5, 1'b0);
        quiet_tx = 1'b0;
        drain_results();
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_config_extremes();
        test_random();
        test_backpressure();
        test_random();
        set_config(3, 768);
        send_set(10, 1'b0);
        drain_results();
        repeat (200) @(negedge clk);
        if (fail_count == 0 && stats_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver stall: random per item, or one long hold counted here.
    initial
    begin
        int w;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                rx_hold = 1'b0;
                out_stall <= 1'b1;
                for (int c = 0; c < 3000; c++)
                    @(negedge clk);
            end
            w = quiet_rx ? 0 : $urandom_range(0, 15);
            if (w != 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (stats_queue.size() == 0)
            begin
                $error("result with no expectation");
                fail_count++;
            end
            else
            begin
                exp_r = stats_queue.pop_front();
                if (out_data.mean_q8 !== exp_r.mean_q8)
                begin
                    $error("mean_q8 exp %0d got %0d", exp_r.mean_q8, out_data.mean_q8);
                    fail_count++;
                end
                if (out_data.stddev_q8 !== exp_r.stddev_q8)
                begin
                    $error("stddev_q8 exp %0d got %0d", exp_r.stddev_q8,
                           out_data.stddev_q8);
                    fail_count++;
                end
                if (out_data.kept_count !== exp_r.kept_count)
                begin
                    $error("kept_count exp %0d got %0d", exp_r.kept_count,
                           out_data.kept_count);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
design/scs_pkg.sv
design/scs_ram.sv
design/scs_iter.sv
design/sigma_clipped_stats.sv
bench/tb.sv
